/* design/jhss_pkg.sv */
// shared types and constants for the jpeg header size scanner
// no dependencies
package jhss_pkg;

	localparam logic [7:0] MARK_PREFIX = 8'hFF;
	localparam logic [7:0] MARK_SOI    = 8'hD8;
	localparam logic [7:0] MARK_SOF_LO = 8'hC0;
	localparam logic [7:0] MARK_SOF_HI = 8'hCF;
	localparam logic [7:0] MARK_DHT    = 8'hC4;
	localparam logic [7:0] MARK_JPG    = 8'hC8;
	localparam logic [7:0] MARK_DAC    = 8'hCC;
	localparam logic [7:0] MARK_SOS    = 8'hDA;
	localparam logic [7:0] MARK_EOI    = 8'hD9;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NOSOI   = 3'd1,
		ST_JUNK    = 3'd2,
		ST_BADLEN  = 3'd3,
		ST_SCANEND = 3'd4,
		ST_TRUNC   = 3'd5
	} status_t;

	typedef enum logic [14:0] {
		PH_SOI0    = 15'h0001,
		PH_SOI1    = 15'h0002,
		PH_HUNT    = 15'h0004,
		PH_MARK    = 15'h0008,
		PH_LEN_HI  = 15'h0010,
		PH_LEN_LO  = 15'h0020,
		PH_SKIP    = 15'h0040,
		PH_FLEN_HI = 15'h0080,
		PH_FLEN_LO = 15'h0100,
		PH_PREC    = 15'h0200,
		PH_H_HI    = 15'h0400,
		PH_H_LO    = 15'h0800,
		PH_W_HI    = 15'h1000,
		PH_W_LO    = 15'h2000,
		PH_COMP    = 15'h4000
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} item_t;

	typedef struct packed {
		logic        valid;
		status_t     status;
		logic [15:0] width;
		logic [15:0] height;
	} result_t;

	function automatic logic is_frame_marker(input logic [7:0] m);
		return (m >= MARK_SOF_LO) && (m <= MARK_SOF_HI) &&
			(m != MARK_DHT) && (m != MARK_JPG) && (m != MARK_DAC);
	endfunction

endpackage

/* design/jpeg_header_size_scanner_top.sv */
// jpeg header size scanner: input register, parser, result register
// a result is registered: the parser decides on the byte held in the input register, and the result register offers it
// throughput: one byte per cycle; a held result only stalls the input when a
// second result is ready behind it
// reset: arst_n clears the parser to expect the start marker and empties both registers
// depends on jhss_pkg and jhss_parser
module jpeg_header_size_scanner_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        file_start,
	input  logic        file_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] width,
	output logic [15:0] height
);

	logic              valid_s1;
	jhss_pkg::item_t   item_s1;
	jhss_pkg::result_t res;
	logic              advance_s1;
	logic              step;
	logic              out_free;
	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [15:0]       width_q;
	logic [15:0]       height_q;

	assign out_free   = !out_valid_q || !out_stall;
	assign advance_s1 = !res.valid || out_free;
	assign step       = valid_s1 && advance_s1;
	assign in_stall   = valid_s1 && !advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{data: data_byte, first: file_start, last: file_end};
		end
	end

	jhss_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step && res.valid) begin
			status_q <= res.status;
			width_q  <= res.width;
			height_q <= res.height;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign width     = width_q;
	assign height    = height_q;

endmodule

/* design/jhss_parser.sv */
// marker segment parser: parse state and per-byte next-state logic
// depends on jhss_pkg
module jhss_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  jhss_pkg::item_t   item,
	output jhss_pkg::result_t res
);

	jhss_pkg::phase_t phase_q, phase_e, phase_d;
	logic             junk_q, junk_e, junk_d;
	logic [15:0]      remain_q, remain_e, remain_d;
	logic [7:0]       len_hi_q, len_hi_e, len_hi_d;
	logic [15:0]      height_q, height_e, height_d;
	logic [15:0]      width_q, width_e, width_d;
	logic             decided_q, decided_e, decided_d;
	logic [15:0]      seg_len;
	logic [15:0]      remain_dec;
	logic             hit;
	jhss_pkg::status_t st;

	// a new file clears all parse state before the byte is looked at
	always_comb begin
		phase_e   = item.first ? jhss_pkg::PH_SOI0 : phase_q;
		junk_e    = item.first ? 1'b0 : junk_q;
		remain_e  = item.first ? 16'd0 : remain_q;
		len_hi_e  = item.first ? 8'd0 : len_hi_q;
		height_e  = item.first ? 16'd0 : height_q;
		width_e   = item.first ? 16'd0 : width_q;
		decided_e = item.first ? 1'b0 : decided_q;
	end

	assign seg_len    = {len_hi_e, item.data};
	assign remain_dec = remain_e - 16'd1;

	always_comb begin
		phase_d   = phase_e;
		junk_d    = junk_e;
		remain_d  = remain_e;
		len_hi_d  = len_hi_e;
		height_d  = height_e;
		width_d   = width_e;
		decided_d = decided_e;
		hit       = 1'b0;
		st        = jhss_pkg::ST_OK;
		if (!decided_e) begin
			unique case (phase_e)
				jhss_pkg::PH_SOI0: begin
					if (item.data != jhss_pkg::MARK_PREFIX) begin
						hit = 1'b1;
						st  = jhss_pkg::ST_NOSOI;
					end else begin
						phase_d = jhss_pkg::PH_SOI1;
					end
				end
				jhss_pkg::PH_SOI1: begin
					if (item.data != jhss_pkg::MARK_SOI) begin
						hit = 1'b1;
						st  = jhss_pkg::ST_NOSOI;
					end else begin
						phase_d = jhss_pkg::PH_HUNT;
						junk_d  = 1'b0;
					end
				end
				jhss_pkg::PH_HUNT: begin
					if (item.data == jhss_pkg::MARK_PREFIX) begin
						phase_d = jhss_pkg::PH_MARK;
					end else begin
						junk_d = 1'b1;
					end
				end
				jhss_pkg::PH_MARK: begin
					if (item.data == jhss_pkg::MARK_PREFIX) begin
						phase_d = jhss_pkg::PH_MARK;
					end else if (junk_e) begin
						hit = 1'b1;
						st  = jhss_pkg::ST_JUNK;
					end else if (jhss_pkg::is_frame_marker(item.data)) begin
						phase_d = jhss_pkg::PH_FLEN_HI;
					end else if (item.data == jhss_pkg::MARK_SOS ||
							item.data == jhss_pkg::MARK_EOI) begin
						hit = 1'b1;
						st  = jhss_pkg::ST_SCANEND;
					end else begin
						phase_d = jhss_pkg::PH_LEN_HI;
					end
				end
				jhss_pkg::PH_LEN_HI: begin
					len_hi_d = item.data;
					phase_d  = jhss_pkg::PH_LEN_LO;
				end
				jhss_pkg::PH_LEN_LO: begin
					if (seg_len < 16'd2) begin
						hit = 1'b1;
						st  = jhss_pkg::ST_BADLEN;
					end else begin
						remain_d = seg_len - 16'd2;
						junk_d   = 1'b0;
						phase_d  = (seg_len == 16'd2) ? jhss_pkg::PH_HUNT : jhss_pkg::PH_SKIP;
					end
				end
				jhss_pkg::PH_SKIP: begin
					remain_d = remain_dec;
					if (remain_dec == 16'd0) begin
						junk_d  = 1'b0;
						phase_d = jhss_pkg::PH_HUNT;
					end
				end
				jhss_pkg::PH_FLEN_HI: phase_d = jhss_pkg::PH_FLEN_LO;
				jhss_pkg::PH_FLEN_LO: phase_d = jhss_pkg::PH_PREC;
				jhss_pkg::PH_PREC:    phase_d = jhss_pkg::PH_H_HI;
				jhss_pkg::PH_H_HI: begin
					height_d = {item.data, 8'd0};
					phase_d  = jhss_pkg::PH_H_LO;
				end
				jhss_pkg::PH_H_LO: begin
					height_d = {height_e[15:8], item.data};
					phase_d  = jhss_pkg::PH_W_HI;
				end
				jhss_pkg::PH_W_HI: begin
					width_d = {item.data, 8'd0};
					phase_d = jhss_pkg::PH_W_LO;
				end
				jhss_pkg::PH_W_LO: begin
					width_d = {width_e[15:8], item.data};
					phase_d = jhss_pkg::PH_COMP;
				end
				jhss_pkg::PH_COMP: begin
					hit = 1'b1;
					st  = jhss_pkg::ST_OK;
				end
				default: phase_d = jhss_pkg::PH_SOI0;
			endcase
			if (!hit && item.last) begin
				hit = 1'b1;
				st  = jhss_pkg::ST_TRUNC;
			end
			if (hit) begin
				decided_d = 1'b1;
			end
		end
	end

	always_comb begin
		res.valid  = hit;
		res.status = st;
		res.width  = (st == jhss_pkg::ST_OK) ? width_e : 16'd0;
		res.height = (st == jhss_pkg::ST_OK) ? height_e : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= jhss_pkg::PH_SOI0;
			junk_q    <= 1'b0;
			remain_q  <= 16'd0;
			len_hi_q  <= 8'd0;
			height_q  <= 16'd0;
			width_q   <= 16'd0;
			decided_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			junk_q    <= junk_d;
			remain_q  <= remain_d;
			len_hi_q  <= len_hi_d;
			height_q  <= height_d;
			width_q   <= width_d;
			decided_q <= decided_d;
		end
	end

endmodule

/* design/jhss_checker.sv */
// port-level checks for the jpeg header size scanner, bound to the top level
// depends on jhss_pkg and jpeg_header_size_scanner_top
module jhss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  data_byte,
	input logic        file_start,
	input logic        file_end,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [15:0] width,
	input logic [15:0] height
);

	// stalled input item keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(data_byte) && $stable(file_start) &&
			$stable(file_end))
		else $error("stalled input item changed");

	// held result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(width) &&
			$stable(height))
		else $error("held item changed");

	// input backs up only behind a held result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free output");

	// only defined status codes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= 3'(jhss_pkg::ST_TRUNC))
		else $error("undefined status");

	// size fields are zero on every failure
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 3'(jhss_pkg::ST_OK) |-> width == 16'd0 && height == 16'd0)
		else $error("size on failure");

endmodule

bind jpeg_header_size_scanner_top jhss_checker u_jhss_checker (.*);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// testbench for jpeg_header_size_scanner_top: directed and random byte streams with
// an in-bench scanner model checking every report; depends on jhss_pkg and the design
module testbench;

	typedef struct {
		jhss_pkg::status_t status;
		logic [15:0]       width;
		logic [15:0]       height;
	} size_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        file_start = 1'b0;
	logic        file_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [15:0] width;
	logic [15:0] height;

	// scanner model state
	jhss_pkg::phase_t scan_phase;
	bit               scan_junk;
	logic [15:0]      scan_left;
	logic [7:0]       scan_len_hi;
	logic [15:0]      scan_height;
	logic [15:0]      scan_width;
	bit               scan_done;

	size_report_t size_reports[$];
	size_report_t got_report;
	logic [7:0]   file_bytes[$];

	int errors = 0;
	int sent_items = 0;
	int parsed_items = 0;
	int checked_reports = 0;
	int file_count = 0;
	int status_seen[6];
	int sink_hold = 0;
	bit src_idle_on = 1'b1;
	bit sink_idle_on = 1'b1;

	jpeg_header_size_scanner_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.file_start(file_start),
		.file_end(file_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.width(width),
		.height(height)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("%0t: run did not finish in time", $time);
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic bit starts_frame(input logic [7:0] code);
		if (code[7:4] != 4'hC)
			return 1'b0;
		return (code[1:0] != 2'b00) || (code[3:2] == 2'b00);
	endfunction

	function automatic logic [7:0] skip_marker();
		logic [7:0] m;
		do
			m = 8'($urandom_range(1, 254));
		while (starts_frame(m) || m == jhss_pkg::MARK_SOS || m == jhss_pkg::MARK_EOI);
		return m;
	endfunction

	function automatic logic [15:0] pick_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'h0000;
		if (r == 1)
			return 16'hFFFF;
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic clear_scan();
		scan_phase = jhss_pkg::PH_SOI0;
		scan_junk = 1'b0;
		scan_left = 16'd0;
		scan_len_hi = 8'd0;
		scan_height = 16'd0;
		scan_width = 16'd0;
		scan_done = 1'b0;
	endtask

	task automatic predict_scan(input logic [7:0] b, input logic first, input logic last,
			output bit parsed);
		jhss_pkg::status_t st;
		bit                hit;
		logic [15:0]       seg_len;
		size_report_t      rep;
		hit = 1'b0;
		st = jhss_pkg::ST_OK;
		parsed = 1'b0;
		if (first)
			clear_scan();
		if (scan_done)
			return;
		parsed = 1'b1;
		seg_len = {scan_len_hi, b};
		case (scan_phase)
			jhss_pkg::PH_SOI0: begin
				if (b == jhss_pkg::MARK_PREFIX) begin
					scan_phase = jhss_pkg::PH_SOI1;
				end else begin
					hit = 1'b1;
					st = jhss_pkg::ST_NOSOI;
				end
			end
			jhss_pkg::PH_SOI1: begin
				if (b == jhss_pkg::MARK_SOI) begin
					scan_phase = jhss_pkg::PH_HUNT;
					scan_junk = 1'b0;
				end else begin
					hit = 1'b1;
					st = jhss_pkg::ST_NOSOI;
				end
			end
			jhss_pkg::PH_HUNT: begin
				if (b == jhss_pkg::MARK_PREFIX)
					scan_phase = jhss_pkg::PH_MARK;
				else
					scan_junk = 1'b1;
			end
			jhss_pkg::PH_MARK: begin
				if (b != jhss_pkg::MARK_PREFIX) begin
					if (scan_junk) begin
						hit = 1'b1;
						st = jhss_pkg::ST_JUNK;
					end else if (starts_frame(b)) begin
						scan_phase = jhss_pkg::PH_FLEN_HI;
					end else if (b == jhss_pkg::MARK_SOS || b == jhss_pkg::MARK_EOI) begin
						hit = 1'b1;
						st = jhss_pkg::ST_SCANEND;
					end else begin
						scan_phase = jhss_pkg::PH_LEN_HI;
					end
				end
			end
			jhss_pkg::PH_LEN_HI: begin
				scan_len_hi = b;
				scan_phase = jhss_pkg::PH_LEN_LO;
			end
			jhss_pkg::PH_LEN_LO: begin
				if (seg_len < 16'd2) begin
					hit = 1'b1;
					st = jhss_pkg::ST_BADLEN;
				end else begin
					scan_left = seg_len - 16'd2;
					scan_junk = 1'b0;
					if (scan_left == 16'd0)
						scan_phase = jhss_pkg::PH_HUNT;
					else
						scan_phase = jhss_pkg::PH_SKIP;
				end
			end
			jhss_pkg::PH_SKIP: begin
				scan_left = scan_left - 16'd1;
				if (scan_left == 16'd0) begin
					scan_junk = 1'b0;
					scan_phase = jhss_pkg::PH_HUNT;
				end
			end
			jhss_pkg::PH_FLEN_HI: scan_phase = jhss_pkg::PH_FLEN_LO;
			jhss_pkg::PH_FLEN_LO: scan_phase = jhss_pkg::PH_PREC;
			jhss_pkg::PH_PREC: scan_phase = jhss_pkg::PH_H_HI;
			jhss_pkg::PH_H_HI: begin
				scan_height = {b, 8'h00};
				scan_phase = jhss_pkg::PH_H_LO;
			end
			jhss_pkg::PH_H_LO: begin
				scan_height[7:0] = b;
				scan_phase = jhss_pkg::PH_W_HI;
			end
			jhss_pkg::PH_W_HI: begin
				scan_width = {b, 8'h00};
				scan_phase = jhss_pkg::PH_W_LO;
			end
			jhss_pkg::PH_W_LO: begin
				scan_width[7:0] = b;
				scan_phase = jhss_pkg::PH_COMP;
			end
			jhss_pkg::PH_COMP: begin
				hit = 1'b1;
				st = jhss_pkg::ST_OK;
			end
			default: scan_phase = jhss_pkg::PH_SOI0;
		endcase
		if (!hit && last) begin
			hit = 1'b1;
			st = jhss_pkg::ST_TRUNC;
		end
		if (hit) begin
			scan_done = 1'b1;
			rep.status = st;
			rep.width = (st == jhss_pkg::ST_OK) ? scan_width : 16'd0;
			rep.height = (st == jhss_pkg::ST_OK) ? scan_height : 16'd0;
			size_reports.push_back(rep);
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
		int gap;
		bit parsed;
		gap = src_idle_on ? idle_len() : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		data_byte = b;
		file_start = first;
		file_end = last;
		do
			@(posedge clk);
		while (in_stall);
		predict_scan(b, first, last, parsed);
		sent_items++;
		if (parsed)
			parsed_items++;
	endtask

	task automatic send_file(input bit with_start, input bit with_end, input bit noisy);
		logic first;
		logic last;
		for (int i = 0; i < file_bytes.size(); i++) begin
			first = (i == 0) ? with_start : (noisy && $urandom_range(0, 7) == 0);
			last = (i == file_bytes.size() - 1) ? with_end :
				(noisy && $urandom_range(0, 7) == 0);
			send_byte(file_bytes[i], first, last);
		end
		file_count++;
	endtask

	task automatic drain_reports();
		@(negedge clk);
		in_valid = 1'b0;
		while (size_reports.size() != 0)
			@(posedge clk);
	endtask

	// a byte parsed before any file_start, then one ignored byte
	task automatic test_reset_start();
		file_bytes = {8'h00, 8'hFF};
		send_file(1'b0, 1'b0, 1'b0);
	endtask

	task automatic test_junk_marker();
		file_bytes = {8'hFF, 8'hD8, 8'h12, 8'hFF, 8'hC4};
		send_file(1'b1, 1'b0, 1'b0);
	endtask

	// zero payload segment, then a length of one
	task automatic test_segment_lengths();
		file_bytes = {8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h02, 8'hFF, 8'hDB, 8'h00, 8'h01};
		send_file(1'b1, 1'b0, 1'b0);
	endtask

	// skipped segment, fill byte, size found on the last byte of the file
	task automatic test_frame_size();
		file_bytes = {8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h03, 8'hAA, 8'hFF, 8'hFF, 8'hC2,
			8'h00, 8'h11, 8'h08, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h03};
		send_file(1'b1, 1'b1, 1'b0);
	endtask

	task automatic test_scan_marker();
		file_bytes = {8'hFF, 8'hD8, 8'hFF, 8'hDA};
		send_file(1'b1, 1'b1, 1'b0);
		drain_reports();
	endtask

	task automatic test_truncation();
		file_bytes = {8'hFF, 8'hD8, 8'hFF};
		send_file(1'b1, 1'b1, 1'b0);
	endtask

	task automatic build_random_file(output bit noisy);
		int kind;
		int r;
		int cut;
		logic [15:0] seg_len;
		logic [15:0] dim;
		logic [7:0]  code;
		file_bytes.delete();
		kind = $urandom_range(0, 99);
		noisy = (kind < 12);
		if (noisy) begin
			if ($urandom_range(0, 1) == 0)
				file_bytes = {jhss_pkg::MARK_PREFIX, jhss_pkg::MARK_SOI};
			repeat ($urandom_range(1, 16))
				file_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		file_bytes.push_back(($urandom_range(0, 19) == 0) ?
			8'($urandom_range(0, 255)) : jhss_pkg::MARK_PREFIX);
		file_bytes.push_back(($urandom_range(0, 19) == 0) ?
			8'($urandom_range(0, 255)) : jhss_pkg::MARK_SOI);
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(0, 11) == 0)
				repeat ($urandom_range(1, 3))
					file_bytes.push_back(8'($urandom_range(0, 255)));
			file_bytes.push_back(jhss_pkg::MARK_PREFIX);
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 2))
					file_bytes.push_back(jhss_pkg::MARK_PREFIX);
			file_bytes.push_back(skip_marker());
			r = $urandom_range(0, 39);
			if (r == 0)
				seg_len = 16'($urandom_range(0, 1));
			else if (r < 6)
				seg_len = 16'd2;
			else if (r == 6)
				seg_len = 16'($urandom_range(256, 300));
			else
				seg_len = 16'($urandom_range(3, 10));
			file_bytes.push_back(seg_len[15:8]);
			file_bytes.push_back(seg_len[7:0]);
			if (seg_len > 16'd2)
				repeat (seg_len - 16'd2)
					file_bytes.push_back(8'($urandom_range(0, 255)));
		end
		r = $urandom_range(0, 99);
		if (r < 70) begin
			file_bytes.push_back(jhss_pkg::MARK_PREFIX);
			do
				code = 8'($urandom_range(jhss_pkg::MARK_SOF_LO, jhss_pkg::MARK_SOF_HI));
			while (!starts_frame(code));
			file_bytes.push_back(code);
			repeat (3)
				file_bytes.push_back(8'($urandom_range(0, 255)));
			dim = pick_word();
			file_bytes.push_back(dim[15:8]);
			file_bytes.push_back(dim[7:0]);
			dim = pick_word();
			file_bytes.push_back(dim[15:8]);
			file_bytes.push_back(dim[7:0]);
			file_bytes.push_back(8'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 3))
				file_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (r < 85) begin
			file_bytes.push_back(jhss_pkg::MARK_PREFIX);
			file_bytes.push_back(($urandom_range(0, 1) == 0) ?
				jhss_pkg::MARK_SOS : jhss_pkg::MARK_EOI);
		end
		if ($urandom_range(0, 7) == 0 && file_bytes.size() > 1) begin
			cut = $urandom_range(1, file_bytes.size() - 1);
			while (file_bytes.size() > cut)
				void'(file_bytes.pop_back());
		end
	endtask

	task automatic test_random_files();
		int goal;
		bit noisy;
		goal = sent_items + 600;
		while (sent_items < goal) begin
			if ($urandom_range(0, 7) == 0)
				src_idle_on = !src_idle_on;
			if ($urandom_range(0, 7) == 0)
				sink_idle_on = !sink_idle_on;
			build_random_file(noisy);
			send_file($urandom_range(0, 19) != 0, $urandom_range(0, 9) != 0, noisy);
			if ($urandom_range(0, 11) == 0)
				drain_reports();
		end
	endtask

	always @(negedge clk) begin
		if (sink_hold != 0) begin
			out_stall = 1'b1;
			sink_hold--;
		end else begin
			out_stall = 1'b0;
			if (sink_idle_on)
				sink_hold = idle_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (size_reports.size() == 0) begin
				errors++;
				$display("%0t: unexpected report status %0d width %0d height %0d",
					$time, status, width, height);
			end else begin
				got_report = size_reports.pop_front();
				checked_reports++;
				status_seen[got_report.status]++;
				if (status !== got_report.status) begin
					errors++;
					$display("%0t: status expected %0d got %0d", $time, got_report.status, status);
				end
				if (width !== got_report.width) begin
					errors++;
					$display("%0t: width expected %0d got %0d", $time, got_report.width, width);
				end
				if (height !== got_report.height) begin
					errors++;
					$display("%0t: height expected %0d got %0d", $time, got_report.height, height);
				end
			end
		end
	end

	initial begin
		int waited;
		clear_scan();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_start();
		test_junk_marker();
		test_segment_lengths();
		test_frame_size();
		test_scan_marker();
		test_truncation();
		test_random_files();
		@(negedge clk);
		in_valid = 1'b0;
		waited = 0;
		while (size_reports.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		while (size_reports.size() != 0) begin
			got_report = size_reports.pop_front();
			errors++;
			$display("%0t: missing report status %0d width %0d height %0d", $time,
				got_report.status, got_report.width, got_report.height);
		end
		$display("%0d files, %0d bytes sent, %0d parsed before a decision, %0d reports checked",
			file_count, sent_items, parsed_items, checked_reports);
		$display("reports: size %0d, no start %0d, junk %0d, bad length %0d, %s %0d, %s %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3],
			"scan/end", status_seen[4], "truncated", status_seen[5]);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
